FILE: rtl/hsi_pkg.sv
// Shared constants, types and hash function for the hash set intersection unit.
package hsi_pkg;

  localparam int unsigned SET_CAPACITY = 256;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned IDX_W        = $clog2(SET_CAPACITY);
  localparam int unsigned TBL_DEPTH    = 1 << IDX_W;
  localparam int unsigned CNT_W        = $clog2(SET_CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_PROBE  = 2'd2
  } action_e;

  typedef struct packed {
    logic accept;
    logic advance;
    logic finish;
    logic found;
    logic load_out;
  } hsi_cmd_t;

  typedef struct packed {
    logic needs_search;
    logic slot_valid;
    logic match;
    logic last_step;
    logic out_free;
  } hsi_sts_t;

  function automatic logic [IDX_W-1:0] hsi_hash(input logic [VALUE_W-1:0] v);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ v[i];
    end
    return h;
  endfunction

endpackage

FILE: rtl/hsi_ctrl.sv
// Controller state machine: sequences hashing, bucket probing and result handoff.
module hsi_ctrl import hsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hsi_sts_t sts_i,
  output hsi_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.needs_search ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.slot_valid && sts_i.match) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = 1'b1;
          state_d      = ST_DONE;
        end else if (!sts_i.slot_valid || sts_i.last_step) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/hsi_datapath.sv
// Datapath: hash table memory, valid bits, member count and result register.
module hsi_datapath import hsi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                action_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic signed [VALUE_W-1:0] result_value_o,
  output logic                      hit_o,
  output logic                      status_o,
  input  hsi_cmd_t                  cmd_i,
  output hsi_sts_t                  sts_o
);

  logic [VALUE_W-1:0] mem [TBL_DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  logic [TBL_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]     count_q;
  logic [1:0]           action_q;
  logic [VALUE_W-1:0]   value_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     step_q;
  logic                 res_hit_q;
  logic                 res_status_q;

  logic                 out_valid_q;
  logic [VALUE_W-1:0]   out_value_q;
  logic                 out_hit_q;
  logic                 out_status_q;

  logic full;
  logic do_write;

  assign full     = (count_q == CNT_W'(SET_CAPACITY));
  assign do_write = cmd_i.finish && !cmd_i.found && (action_q == ACT_INSERT)
                    && !full && !valid_q[idx_q];

  assign sts_o.needs_search = (action_i == ACT_INSERT) || (action_i == ACT_PROBE);
  assign sts_o.slot_valid   = valid_q[idx_q];
  assign sts_o.match        = (rdata_q == value_q);
  assign sts_o.last_step    = (step_q == {IDX_W{1'b1}});
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[idx_q] <= value_q;
    end
    rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q     <= action_i;
      value_q      <= value_i;
      idx_q        <= hsi_hash(value_i);
      step_q       <= '0;
      res_hit_q    <= 1'b0;
      res_status_q <= 1'b0;
    end else if (cmd_i.advance) begin
      idx_q  <= idx_q + 1'b1;
      step_q <= step_q + 1'b1;
    end else if (cmd_i.finish) begin
      if (cmd_i.found) begin
        res_hit_q <= (action_q == ACT_PROBE);
      end else if ((action_q == ACT_INSERT) && full) begin
        res_status_q <= 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      out_value_q  <= value_q;
      out_hit_q    <= res_hit_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && (action_i == ACT_CLEAR)) begin
        valid_q <= '0;
        count_q <= '0;
      end else if (do_write) begin
        valid_q[idx_q] <= 1'b1;
        count_q        <= count_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign hit_o          = out_hit_q;
  assign status_o       = out_status_q;

endmodule

FILE: rtl/hash_set_intersection_unit.sv
// Top level of the hash set intersection unit: controller, datapath and checks.
//
//  channel   direction  handshake               payload
//  request   in         in_valid_i / in_ready_o  action_i, value_i
//  result    out        out_valid_o / out_ready_i result_value_o, hit_o, status_o
//
// Insert and probe read and compare the hashed bucket, then step on to further buckets
// by linear probing (at most the table size in all), with a read and a compare per bucket,
// set by the single read port of the table memory. Clear and unused codes skip the search.
// Reset clears the valid bits at once; no clearing pass is needed.
// A new request is taken while the previous result waits in the output register;
// a stalled output holds the controller only once the next result is ready.
module hash_set_intersection_unit import hsi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] result_value_o,
  output logic                      hit_o,
  output logic                      status_o
);

  hsi_cmd_t cmd;
  hsi_sts_t sts;

  hsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsi_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .value_i        (value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o),
    .hit_o          (hit_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  a_found_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish && cmd.found) |-> sts.slot_valid)
    else $error("hit reported on an empty bucket");

  a_probe_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.advance |-> !sts.last_step)
    else $error("probe sequence ran past the table");

endmodule

FILE: tb/tb_hash_set_intersection_unit.sv
// Self-checking testbench for the hash set intersection unit with an in-bench membership model.
module tb_hash_set_intersection_unit;
  import hsi_pkg::*;

  localparam logic [1:0] ACT_UNUSED       = 2'd3;
  localparam int         HALF_PERIOD      = 10;
  localparam int         RESET_CYCLES     = 4;
  localparam int         RANDOM_ITEMS     = 600;
  localparam int         QUIET_TAIL       = 80;
  localparam int         LONG_HOLD_AT     = 150;
  localparam int         LONG_HOLD_CYCLES = 300;
  localparam int         DRAIN_CYCLES     = 2 * TBL_DEPTH + 16;
  localparam longint     TIMEOUT          = 60_000_000;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } set_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      hit;
    logic                      status;
  } set_rsp_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                action_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [VALUE_W-1:0] result_value_o;
  logic                      hit_o;
  logic                      status_o;

  set_req_t    pending_reqs[$];
  set_rsp_t    expected_results[$];
  bit          set_members[logic [VALUE_W-1:0]];
  int unsigned member_total;
  int unsigned mismatches;
  int unsigned reqs_accepted;
  bit          req_taken;
  int          send_gap;
  int          hold_left;
  bit          long_hold_done;

  hash_set_intersection_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .hit_o          (hit_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic set_rsp_t predict_set_result(input set_req_t req);
    set_rsp_t rsp;
    rsp.value  = req.value;
    rsp.hit    = 1'b0;
    rsp.status = 1'b0;
    case (req.action)
      ACT_CLEAR: begin
        set_members.delete();
        member_total = 0;
      end
      ACT_INSERT: begin
        if (!set_members.exists(req.value)) begin
          if (member_total < SET_CAPACITY) begin
            set_members[req.value] = 1'b1;
            member_total++;
          end else begin
            rsp.status = 1'b1;
          end
        end
      end
      ACT_PROBE: rsp.hit = (set_members.exists(req.value) != 0);
      default: ;
    endcase
    return rsp;
  endfunction

  // same bucket: bits k and k+IDX_W fold onto the same hash bit
  function automatic logic [VALUE_W-1:0] bucket_twin(input logic [VALUE_W-1:0] v);
    int k;
    k = $urandom_range(0, VALUE_W - IDX_W - 1);
    return v ^ ((32'h1 << k) | (32'h1 << (k + IDX_W)));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_request(input logic [1:0] action, input logic [VALUE_W-1:0] value);
    set_req_t req;
    req.action = action;
    req.value  = value;
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: queue_request(ACT_UNUSED, $urandom());
      1: queue_request(ACT_CLEAR, $urandom());
      default: queue_request(ACT_INSERT, $urandom());
    endcase
  endtask

  task automatic queue_list_sequence();
    logic [VALUE_W-1:0] pool[$];
    logic [VALUE_W-1:0] v;
    int                 pool_n;
    int                 n_ins;
    int                 n_probe;
    queue_request(ACT_CLEAR, $urandom());
    pool_n = $urandom_range(1, 40);
    for (int i = 0; i < pool_n; i++) begin
      v = $urandom();
      if (i > 0 && $urandom_range(0, 3) == 0) v = bucket_twin(pool[$urandom_range(0, i - 1)]);
      pool = {pool, v};
    end
    n_ins = $urandom_range(1, 2 * pool_n);
    for (int i = 0; i < n_ins; i++) begin
      if ($urandom_range(0, 19) == 0) queue_noise();
      else if ($urandom_range(0, 5) == 0)
        queue_request(ACT_PROBE, pool[$urandom_range(0, pool_n - 1)]);
      else queue_request(ACT_INSERT, pool[$urandom_range(0, pool_n - 1)]);
    end
    n_probe = $urandom_range(1, 40);
    for (int i = 0; i < n_probe; i++) begin
      if ($urandom_range(0, 19) == 0) queue_noise();
      else if ($urandom_range(0, 9) < 7)
        queue_request(ACT_PROBE, pool[$urandom_range(0, pool_n - 1)]);
      else queue_request(ACT_PROBE, $urandom());
    end
  endtask

  task automatic queue_full_set_sequence();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] first_v;
    logic [VALUE_W-1:0] dropped_v;
    queue_request(ACT_CLEAR, $urandom());
    v = $urandom();
    first_v = v;
    queue_request(ACT_INSERT, v);
    for (int i = 1; i < SET_CAPACITY; i++) begin
      v = (i % 4 == 3) ? bucket_twin(v) : $urandom();
      queue_request(ACT_INSERT, v);
    end
    repeat (6) begin
      dropped_v = $urandom();
      queue_request(ACT_INSERT, dropped_v);
    end
    queue_request(ACT_INSERT, first_v);
    queue_request(ACT_INSERT, v);
    queue_request(ACT_PROBE, first_v);
    queue_request(ACT_PROBE, v);
    queue_request(ACT_PROBE, dropped_v);
    queue_request(ACT_PROBE, bucket_twin(v));
    queue_request(ACT_UNUSED, $urandom());
  endtask

  // request driver
  always @(negedge clk_i) begin
    set_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= nxt.action;
        value_i    <= nxt.value;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && reqs_accepted >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (pending_reqs.size() <= QUIET_TAIL) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(1, 18) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: retire results first, then predict the newly taken request
  always @(posedge clk_i) begin
    set_rsp_t exp;
    set_req_t req;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0h", result_value_o));
        end else begin
          exp = expected_results.pop_front();
          if (result_value_o !== exp.value)
            report_mismatch($sformatf("value got %0h exp %0h", result_value_o, exp.value));
          if (hit_o !== exp.hit)
            report_mismatch($sformatf("hit got %b exp %b (value %0h)", hit_o, exp.hit,
                                      exp.value));
          if (status_o !== exp.status)
            report_mismatch($sformatf("status got %b exp %b (value %0h)", status_o,
                                      exp.status, exp.value));
        end
      end
      if (in_valid_i && in_ready_o) begin
        req.action = action_i;
        req.value  = value_i;
        expected_results = {expected_results, predict_set_result(req)};
        reqs_accepted++;
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    int directed_n;
    int seq_idx;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_CLEAR;
    value_i      = '0;
    out_ready_i  = 1'b0;
    member_total = 0;

    queue_request(ACT_CLEAR, 32'hdead_beef);
    queue_request(ACT_INSERT, 32'h0000_0000);
    queue_request(ACT_INSERT, 32'h8000_0000);
    queue_request(ACT_INSERT, 32'h7fff_ffff);
    queue_request(ACT_INSERT, 32'hffff_ffff);
    queue_request(ACT_INSERT, 32'h0000_0000);
    queue_request(ACT_INSERT, 32'h0000_0101);
    queue_request(ACT_PROBE, 32'h0000_0000);
    queue_request(ACT_PROBE, 32'h0000_0101);
    queue_request(ACT_PROBE, 32'h0000_0202);
    queue_request(ACT_PROBE, 32'h8000_0000);
    queue_request(ACT_PROBE, 32'h7fff_ffff);
    queue_request(ACT_PROBE, 32'hffff_ffff);
    queue_request(ACT_PROBE, 32'h0000_0001);
    queue_request(ACT_UNUSED, 32'h5555_5555);
    queue_request(ACT_PROBE, 32'h5555_5555);
    queue_request(ACT_CLEAR, 32'haaaa_aaaa);
    queue_request(ACT_PROBE, 32'h0000_0000);
    queue_request(ACT_INSERT, 32'h1234_5678);
    queue_request(ACT_PROBE, 32'h1234_5678);
    directed_n = pending_reqs.size();

    seq_idx = 0;
    while (pending_reqs.size() < directed_n + RANDOM_ITEMS) begin
      if (seq_idx == 2) queue_full_set_sequence();
      else queue_list_sequence();
      seq_idx++;
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("timeout: %0d results still expected", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/hsi_pkg.sv
rtl/hsi_ctrl.sv
rtl/hsi_datapath.sv
rtl/hash_set_intersection_unit.sv
tb/tb_hash_set_intersection_unit.sv
